@@ sv/hcd_pkg.sv @@
// Shared types and constants of the HTTP chunked body decoder.
package hcd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE     = 3'd0,
        PH_DATA     = 3'd1,
        PH_CRLF     = 3'd2,
        PH_DONE     = 3'd3,
        PH_ERR_SIZE = 3'd4,
        PH_ERR_LONG = 3'd5,
        PH_ERR_CRLF = 3'd6
    } hcd_phase_t;

    typedef enum logic [1:0] {
        KIND_FRAMING = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2,
        KIND_ERROR   = 2'd3
    } hcd_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_SIZE  = 2'd1,
        ERR_LINE_LONG = 2'd2,
        ERR_BAD_CRLF  = 2'd3
    } hcd_err_t;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UPR_A = 8'h41;
    localparam logic [7:0] CH_UPR_F = 8'h46;
    localparam logic [7:0] CH_LWR_A = 8'h61;
    localparam logic [7:0] CH_LWR_F = 8'h66;

    localparam int CFG_W = 10;
    localparam logic [CFG_W-1:0] MAX_LINE_RESET = 10'd256;

    // Per-line flags, lowest bit first: started, bad, exactly zero.
    typedef struct packed {
        logic zero;
        logic bad;
        logic started;
    } hcd_flags_t;

    typedef struct packed {
        hcd_phase_t phase;
        logic       in_extension;
        logic       pending_cr;
        hcd_flags_t flags;
    } hcd_ctrl_t;

    typedef struct packed {
        hcd_kind_t  kind;
        logic [7:0] payload_byte;
        logic       chunk_last;
        hcd_err_t   error_code;
    } hcd_result_t;

endpackage

@@ sv/hcd_step.sv @@
// Combinational per-byte state update and classification of the chunked decoder.
module hcd_step #(
    parameter int SIZE_BITS       = 31,
    parameter int LINE_COUNT_BITS = 10
) (
    input  logic [7:0]                 data_byte,
    input  logic [hcd_pkg::CFG_W-1:0]  max_line_len,
    input  hcd_pkg::hcd_ctrl_t         ctrl,
    input  logic [LINE_COUNT_BITS-1:0] line_count,
    input  logic [SIZE_BITS-1:0]       size_accum,
    input  logic [SIZE_BITS-1:0]       bytes_left,
    output hcd_pkg::hcd_ctrl_t         ctrl_next,
    output logic [LINE_COUNT_BITS-1:0] line_count_next,
    output logic [SIZE_BITS-1:0]       size_accum_next,
    output logic [SIZE_BITS-1:0]       bytes_left_next,
    output hcd_pkg::hcd_result_t       result
);
    import hcd_pkg::*;

    localparam int CMP_W = ((LINE_COUNT_BITS > CFG_W) ? LINE_COUNT_BITS : CFG_W) + 1;

    typedef struct packed {
        logic                 ext;
        hcd_flags_t           flags;
        logic [SIZE_BITS-1:0] accum;
    } hcd_sc_t;

    // Lowercase hex digit: bit 4 is valid, bits 3:0 the value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= CH_LWR_A && c <= CH_LWR_F) begin
                d = c - CH_LWR_A + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

    // One character of a size line.
    function automatic hcd_sc_t size_char(input logic [7:0] c_in, input hcd_sc_t s);
        hcd_sc_t    r;
        logic [7:0] c;
        logic [4:0] h;
        begin
            r = s;
            c = c_in;
            if (!s.ext) begin
                if (!s.flags.started) begin
                    r.flags.started = 1'b1;
                    h = hex_digit(c);
                    if (c == CH_ZERO) begin
                        r.flags.bad  = 1'b1;
                        r.flags.zero = 1'b1;
                    end else if (h[4]) begin
                        r.accum = {{(SIZE_BITS-4){1'b0}}, h[3:0]};
                    end else begin
                        r.flags.bad = 1'b1;
                    end
                end else begin
                    r.flags.zero = 1'b0;
                    if (!s.flags.bad) begin
                        if (c >= CH_UPR_A && c <= CH_UPR_F) begin
                            c = c + 8'h20;
                        end
                        h = hex_digit(c);
                        if (h[4]) begin
                            // Another digit would not fit in SIZE_BITS.
                            if (|s.accum[SIZE_BITS-1:SIZE_BITS-4]) begin
                                r.flags.bad = 1'b1;
                            end else begin
                                r.accum = {s.accum[SIZE_BITS-5:0], h[3:0]};
                            end
                        end else if (c == CH_SEMI) begin
                            r.ext = 1'b1;
                        end else begin
                            r.flags.bad = 1'b1;
                        end
                    end
                end
            end else begin
                h = 5'd0;
            end
            size_char = r;
        end
    endfunction

    logic                       too_long;
    logic [LINE_COUNT_BITS-1:0] counted;
    logic                       is_lf;
    logic                       lc_zero;
    logic                       lc_one;
    hcd_sc_t                    sc;

    assign too_long = (CMP_W'(line_count) + CMP_W'(1)) > CMP_W'(max_line_len);
    assign counted  = (line_count != {LINE_COUNT_BITS{1'b1}})
                    ? line_count + LINE_COUNT_BITS'(1) : line_count;
    assign is_lf    = (data_byte == CH_LF);
    assign lc_zero  = (line_count == '0);
    assign lc_one   = (line_count == LINE_COUNT_BITS'(1));

    always_comb begin
        ctrl_next       = ctrl;
        line_count_next = line_count;
        size_accum_next = size_accum;
        bytes_left_next = bytes_left;
        result          = '0;
        result.kind       = KIND_FRAMING;
        result.error_code = ERR_NONE;
        sc = '0;

        unique case (ctrl.phase)
            PH_SIZE: begin
                if (too_long) begin
                    ctrl_next.phase   = PH_ERR_LONG;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_LINE_LONG;
                end else begin
                    line_count_next = counted;
                    if (is_lf) begin
                        if (lc_zero || (lc_one && ctrl.pending_cr)) begin
                            line_count_next = '0;
                            ctrl_next.flags = '0;
                            ctrl_next.in_extension = 1'b0;
                            ctrl_next.pending_cr   = 1'b0;
                            size_accum_next = '0;
                        end else if (ctrl.flags.zero) begin
                            ctrl_next.phase = PH_DONE;
                            result.kind     = KIND_END;
                        end else if (ctrl.flags.bad) begin
                            ctrl_next.phase   = PH_ERR_SIZE;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_BAD_SIZE;
                        end else begin
                            bytes_left_next = size_accum;
                            ctrl_next.phase = (size_accum != '0) ? PH_DATA : PH_CRLF;
                            line_count_next = '0;
                            ctrl_next.flags = '0;
                            ctrl_next.in_extension = 1'b0;
                            ctrl_next.pending_cr   = 1'b0;
                            size_accum_next = '0;
                        end
                    end else begin
                        sc.ext   = ctrl.in_extension;
                        sc.flags = ctrl.flags;
                        sc.accum = size_accum;
                        // A held CR that is not followed by LF is line content.
                        if (ctrl.pending_cr) begin
                            sc = size_char(CH_CR, sc);
                        end
                        ctrl_next.pending_cr = 1'b0;
                        if (data_byte == CH_CR) begin
                            ctrl_next.pending_cr = 1'b1;
                        end else begin
                            sc = size_char(data_byte, sc);
                        end
                        ctrl_next.in_extension = sc.ext;
                        ctrl_next.flags        = sc.flags;
                        size_accum_next        = sc.accum;
                    end
                end
            end
            PH_DATA: begin
                result.kind         = KIND_PAYLOAD;
                result.payload_byte = data_byte;
                bytes_left_next = (bytes_left != '0) ? bytes_left - SIZE_BITS'(1) : bytes_left;
                if (bytes_left_next == '0) begin
                    result.chunk_last = 1'b1;
                    ctrl_next.phase   = PH_CRLF;
                    line_count_next   = '0;
                    ctrl_next.flags   = '0;
                    ctrl_next.in_extension = 1'b0;
                    ctrl_next.pending_cr   = 1'b0;
                    size_accum_next   = '0;
                end
            end
            PH_CRLF: begin
                if (too_long) begin
                    ctrl_next.phase   = PH_ERR_LONG;
                    result.kind       = KIND_ERROR;
                    result.error_code = ERR_LINE_LONG;
                end else begin
                    line_count_next = counted;
                    if (is_lf) begin
                        if (lc_one && !ctrl.flags.bad) begin
                            ctrl_next.phase = PH_SIZE;
                            line_count_next = '0;
                            ctrl_next.flags = '0;
                            ctrl_next.in_extension = 1'b0;
                            ctrl_next.pending_cr   = 1'b0;
                            size_accum_next = '0;
                        end else begin
                            ctrl_next.phase   = PH_ERR_CRLF;
                            result.kind       = KIND_ERROR;
                            result.error_code = ERR_BAD_CRLF;
                        end
                    end else if (!(lc_zero && data_byte == CH_CR)) begin
                        ctrl_next.flags.bad = 1'b1;
                    end
                end
            end
            PH_DONE: begin
                result.kind = KIND_END;
            end
            PH_ERR_SIZE: begin
                result.kind       = KIND_ERROR;
                result.error_code = ERR_BAD_SIZE;
            end
            PH_ERR_LONG: begin
                result.kind       = KIND_ERROR;
                result.error_code = ERR_LINE_LONG;
            end
            default: begin
                ctrl_next.phase   = PH_ERR_CRLF;
                result.kind       = KIND_ERROR;
                result.error_code = ERR_BAD_CRLF;
            end
        endcase
    end

endmodule

@@ sv/http_chunked_decoder_unit.sv @@
// Top level of the HTTP chunked body decoder: state registers, result register, config.
//
// The decoder takes a chunked HTTP message body one byte per word and returns exactly one
// result word for every byte: framing consumed, payload (with m_tlast on the last byte of
// each chunk), end of message, or error with a code. Size lines are hex and are ended by
// LF; one CR before the LF is stripped, text after ';' is ignored, empty lines are skipped
// and a line of exactly "0" ends the message. After end or error the decoder repeats that
// status on every further byte until reset. The unit sustains one byte per clock cycle
// while m_tready is high: the whole per-byte state update, a hex shift-add and a
// line-length compare, is one combinational step between the state registers and the
// result register, so a result appears in the cycle after its byte is taken. The result
// register is a single stage, so s_tready follows m_tready whenever a result is held. The
// max_line_len register (reset 256) is written through cfg_wr_en / cfg_wr_data and must
// only be written while no byte is in flight.
module http_chunked_decoder_unit #(
    parameter int SIZE_BITS       = 31,
    parameter int LINE_COUNT_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input byte stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,    // [7:0] data_byte
    // Result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [15:0]               m_tdata,    // [7:0] payload_byte, [9:8] error_code,
                                                  // [15:10] zero
    output logic                      m_tlast,    // chunk_last
    output logic [1:0]                m_tuser,    // [1:0] kind
    // Configuration: max_line_len.
    input  logic                      cfg_wr_en,
    input  logic [hcd_pkg::CFG_W-1:0] cfg_wr_data
);
    import hcd_pkg::*;

    // Decoder state.
    hcd_ctrl_t                  ctrl_reg, ctrl_next;
    logic [LINE_COUNT_BITS-1:0] line_count_reg, line_count_next;
    logic [SIZE_BITS-1:0]       size_accum_reg, size_accum_next;
    logic [SIZE_BITS-1:0]       bytes_left_reg, bytes_left_next;
    logic [CFG_W-1:0]           max_line_len_reg;

    // Result register.
    logic        out_valid_reg;
    hcd_result_t out_reg;
    hcd_result_t step_result;

    logic in_fire;

    // A new byte is taken whenever the result register is empty or is being drained.
    assign s_tready = !out_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    hcd_step #(
        .SIZE_BITS       (SIZE_BITS),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_step (
        .data_byte       (s_tdata),
        .max_line_len    (max_line_len_reg),
        .ctrl            (ctrl_reg),
        .line_count      (line_count_reg),
        .size_accum      (size_accum_reg),
        .bytes_left      (bytes_left_reg),
        .ctrl_next       (ctrl_next),
        .line_count_next (line_count_next),
        .size_accum_next (size_accum_next),
        .bytes_left_next (bytes_left_next),
        .result          (step_result)
    );

    // State advances only on an accepted byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg         <= '{phase: PH_SIZE, in_extension: 1'b0, pending_cr: 1'b0,
                                  flags: '0};
            line_count_reg   <= '0;
            size_accum_reg   <= '0;
            bytes_left_reg   <= '0;
            max_line_len_reg <= MAX_LINE_RESET;
        end else begin
            if (in_fire) begin
                ctrl_reg       <= ctrl_next;
                line_count_reg <= line_count_next;
                size_accum_reg <= size_accum_next;
                bytes_left_reg <= bytes_left_next;
            end
            if (cfg_wr_en) begin
                max_line_len_reg <= cfg_wr_data;
            end
        end
    end

    // The result valid flag is control state; the result payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.chunk_last;
    assign m_tdata  = {6'd0, out_reg.error_code, out_reg.payload_byte};

    // An error code is only ever reported together with the error kind.
    a_code_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_ERROR) |-> (m_tdata[9:8] == ERR_NONE))
        else $error("error code set on a non-error word");

    // Payload bits and the chunk-last flag stay zero outside payload words.
    a_payload_only_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'd0 && !m_tlast))
        else $error("payload bits set on a non-payload word");

    // Once the message has ended, every further byte reports end of message.
    a_done_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && ctrl_reg.phase == PH_DONE) |=> (m_tvalid && m_tuser == KIND_END))
        else $error("end of message status not repeated");

    // An empty result register never holds off the input.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty result register");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the HTTP chunked body decoder unit.
`timescale 1ns / 1ps

module testbench;
    import hcd_pkg::*;

    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 600000;

    // The ways the one message of the run can finish; the decoder halts after any of them.
    typedef enum int {
        END_PLAIN,
        END_WITH_CR,
        BAD_FIRST_CHAR,
        LEADING_ZERO,
        SIZE_OVERFLOW,
        CR_IN_SIZE,
        SIZE_LINE_LONG,
        CRLF_MISSING,
        CRLF_LINE_LONG,
        ENDING_COUNT
    } ending_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata     = 8'h00;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [15:0]         m_tdata;
    logic                m_tlast;
    logic [1:0]          m_tuser;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;

    // Shared by the stimulus, the result sink and the checker.
    hcd_result_t byte_verdicts[$];
    hcd_result_t oldest_verdict;
    int          error_count    = 0;
    int          accepted_count = 0;
    int          cycle_count;
    bit          no_idle        = 1'b0;
    bit          hold_req       = 1'b0;

    // Decoder state as the testbench tracks it.
    hcd_phase_t       dec_phase;
    hcd_flags_t       line_flags;
    logic [9:0]       line_len;
    logic [30:0]      size_acc;
    logic [30:0]      chunk_left;
    logic             in_ext;
    logic             cr_held;
    logic [CFG_W-1:0] max_len;

    http_chunked_decoder_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [7:0] data_byte
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [7:0] payload_byte, [9:8] error_code
        .m_tlast     (m_tlast),      // chunk_last
        .m_tuser     (m_tuser),      // [1:0] kind
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LWR_A && c <= CH_LWR_F) return int'(c - CH_LWR_A) + 10;
        return -1;
    endfunction

    function automatic void start_line();
        line_len   = '0;
        line_flags = '0;
        in_ext     = 1'b0;
        cr_held    = 1'b0;
        size_acc   = '0;
    endfunction

    function automatic void reset_decoder();
        max_len    = MAX_LINE_RESET;
        dec_phase  = PH_SIZE;
        chunk_left = '0;
        start_line();
    endfunction

    function automatic bit line_full();
        return ({1'b0, line_len} + 11'd1) > {1'b0, max_len};
    endfunction

    function automatic void bump_line_len();
        if (line_len != '1) line_len = line_len + 10'd1;
    endfunction

    // One character of a size line outside the final CR LF.
    function automatic void take_size_char(input logic [7:0] ch);
        logic [7:0] c;
        int         v;
        c = ch;
        if (in_ext) return;
        if (!line_flags.started) begin
            // Only 1-9 and a-f may open a size line; a leading 0 may still be the end line.
            line_flags.started = 1'b1;
            v = hex_val(c);
            if (c == CH_ZERO) begin
                line_flags.bad  = 1'b1;
                line_flags.zero = 1'b1;
            end else if (v > 0) begin
                size_acc = {27'd0, v[3:0]};
            end else begin
                line_flags.bad = 1'b1;
            end
            return;
        end
        line_flags.zero = 1'b0;
        if (line_flags.bad) return;
        if (c >= CH_UPR_A && c <= CH_UPR_F) c = c + (CH_LWR_A - CH_UPR_A);
        v = hex_val(c);
        if (v >= 0) begin
            if (size_acc[30:27] != 4'd0) line_flags.bad = 1'b1;
            else size_acc = {size_acc[26:0], v[3:0]};
        end else if (c == CH_SEMI) begin
            in_ext = 1'b1;
        end else begin
            line_flags.bad = 1'b1;
        end
    endfunction

    function automatic hcd_result_t classify_byte(input logic [7:0] c);
        hcd_result_t r;
        logic [9:0]  prev;
        r.kind         = KIND_FRAMING;
        r.payload_byte = 8'h00;
        r.chunk_last   = 1'b0;
        r.error_code   = ERR_NONE;
        case (dec_phase)
            PH_SIZE: begin
                if (line_full()) begin
                    dec_phase    = PH_ERR_LONG;
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_LINE_LONG;
                end else begin
                    prev = line_len;
                    bump_line_len();
                    if (c == CH_LF) begin
                        if (prev == 10'd0 || (prev == 10'd1 && cr_held)) begin
                            start_line();
                        end else if (line_flags.zero) begin
                            dec_phase = PH_DONE;
                            r.kind    = KIND_END;
                        end else if (line_flags.bad) begin
                            dec_phase    = PH_ERR_SIZE;
                            r.kind       = KIND_ERROR;
                            r.error_code = ERR_BAD_SIZE;
                        end else begin
                            chunk_left = size_acc;
                            dec_phase  = (chunk_left != '0) ? PH_DATA : PH_CRLF;
                            start_line();
                        end
                    end else begin
                        if (cr_held) begin
                            take_size_char(CH_CR);
                            cr_held = 1'b0;
                        end
                        if (c == CH_CR) cr_held = 1'b1;
                        else take_size_char(c);
                    end
                end
            end
            PH_DATA: begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = c;
                if (chunk_left != '0) chunk_left = chunk_left - 31'd1;
                if (chunk_left == '0) begin
                    r.chunk_last = 1'b1;
                    dec_phase    = PH_CRLF;
                    start_line();
                end
            end
            PH_CRLF: begin
                if (line_full()) begin
                    dec_phase    = PH_ERR_LONG;
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_LINE_LONG;
                end else begin
                    prev = line_len;
                    bump_line_len();
                    if (c == CH_LF) begin
                        if (prev == 10'd1 && !line_flags.bad) begin
                            dec_phase = PH_SIZE;
                            start_line();
                        end else begin
                            dec_phase    = PH_ERR_CRLF;
                            r.kind       = KIND_ERROR;
                            r.error_code = ERR_BAD_CRLF;
                        end
                    end else if (!(prev == 10'd0 && c == CH_CR)) begin
                        line_flags.bad = 1'b1;
                    end
                end
            end
            PH_DONE: begin
                r.kind = KIND_END;
            end
            PH_ERR_SIZE: begin
                r.kind       = KIND_ERROR;
                r.error_code = ERR_BAD_SIZE;
            end
            PH_ERR_LONG: begin
                r.kind       = KIND_ERROR;
                r.error_code = ERR_LINE_LONG;
            end
            default: begin
                dec_phase    = PH_ERR_CRLF;
                r.kind       = KIND_ERROR;
                r.error_code = ERR_BAD_CRLF;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (byte_verdicts.size() == 0) begin
                $display("%0t: result word with no byte waiting: kind %0d, tdata %h",
                         $time, m_tuser, m_tdata);
                error_count++;
            end else begin
                oldest_verdict = byte_verdicts.pop_front();
                check_field("kind", 8'(oldest_verdict.kind), 8'(m_tuser));
                check_field("payload_byte", oldest_verdict.payload_byte, m_tdata[7:0]);
                check_field("chunk_last", 8'(oldest_verdict.chunk_last), 8'(m_tlast));
                check_field("error_code", 8'(oldest_verdict.error_code), 8'(m_tdata[9:8]));
                check_field("tdata padding", 8'h00, 8'(m_tdata[15:10]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random back-pressure, plus one long hold on request.
    // ------------------------------------------------------------------

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    initial begin : result_sink
        int gap_left;
        gap_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                // The hold is timed here, so the sender keeps offering bytes meanwhile.
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (gap_left > 0) begin
                m_tready <= 1'b0;
                gap_left--;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0) gap_left = idle_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------

    // Offers one word and waits until the decoder takes it. The valid is only lowered
    // before an idle gap, so back-to-back words keep it high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        byte_verdicts.push_back(classify_byte(b));
        accepted_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stops offering and waits until every outstanding result has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (byte_verdicts.size() != 0) @(posedge aclk);
    endtask

    // The register is only written with nothing in flight; one result per byte means
    // an empty queue shows that no byte is still in flight.
    task automatic write_max_len(input logic [CFG_W-1:0] v);
        drain_results();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        max_len      = v;
    endtask

    function automatic logic [7:0] non_lf_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CH_LF) b = CH_SEMI;
        return b;
    endfunction

    function automatic int random_chunk_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(1, 8);
        if (r < 9) return $urandom_range(9, 40);
        return $urandom_range(41, 255);
    endfunction

    // One well-formed chunk: optional empty line, hex size line with optional extension
    // and CR, random payload, CR LF. Parts are dropped when the line would not fit.
    task automatic send_chunk(input int size);
        int         nd;
        int         nib;
        int         ext_len;
        bit         use_ext;
        bit         use_cr;
        logic [7:0] ch;
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) != 0) send_byte(CH_CR);
            send_byte(CH_LF);
        end
        nd = 1;
        while ((size >> (4 * nd)) != 0) nd++;
        use_ext = ($urandom_range(0, 3) == 0);
        ext_len = $urandom_range(0, 6);
        use_cr  = ($urandom_range(0, 2) != 0);
        if (nd + (use_ext ? ext_len + 1 : 0) + int'(use_cr) + 1 > int'(max_len)) use_ext = 1'b0;
        if (nd + int'(use_cr) + 1 > int'(max_len)) use_cr = 1'b0;
        for (int i = nd - 1; i >= 0; i--) begin
            nib = (size >> (4 * i)) & 15;
            if (nib < 10) ch = CH_ZERO + nib[7:0];
            else if (i != nd - 1 && $urandom_range(0, 1) != 0) ch = CH_UPR_A + nib[7:0] - 8'd10;
            else ch = CH_LWR_A + nib[7:0] - 8'd10;
            send_byte(ch);
        end
        if (use_ext) begin
            send_byte(CH_SEMI);
            repeat (ext_len) send_byte(non_lf_byte());
        end
        if (use_cr) send_byte(CH_CR);
        send_byte(CH_LF);
        repeat (size) send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic send_chunks(input int n_items);
        int first;
        first = accepted_count;
        while (accepted_count - first < n_items) send_chunk(random_chunk_len());
    endtask

    // A size line exactly max_len bytes long, padded out in its extension.
    task automatic send_full_line();
        send_text("1;");
        repeat (int'(max_len) - 3) send_byte(non_lf_byte());
        send_byte(CH_LF);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty lines with and without CR, an extension holding CR, NUL and 0xFF,
    // and payload bytes at both extremes.
    task automatic test_directed();
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("1;");
        send_byte(CH_CR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(8'h00);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("2");
        send_byte(CH_LF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_shortest_lines();
        write_max_len(10'd3);
        send_full_line();
        send_chunks(350);
    endtask

    task automatic test_longest_lines();
        write_max_len(10'd1023);
        send_chunks(350);
    endtask

    // The sink holds off for a long stretch while bytes keep coming, so the result
    // register fills and the input stalls; then the source waits for everything.
    task automatic test_output_stall();
        hold_req = 1'b1;
        send_chunk(24);
        drain_results();
    endtask

    // Random limits, one small; the middle phase runs without any idle cycles.
    task automatic test_random_limits();
        for (int p = 0; p < 3; p++) begin
            if (p == 0) write_max_len(CFG_W'($urandom_range(3, 64)));
            else write_max_len(CFG_W'($urandom_range(3, 1023)));
            no_idle = (p == 1);
            if (p == 0) send_full_line();
            send_chunks(300);
            no_idle = 1'b0;
        end
        write_max_len(MAX_LINE_RESET);
    endtask

    // Finishes the message in one randomly chosen way.
    task automatic test_message_end();
        ending_t    how;
        logic [7:0] b;
        how = ending_t'($urandom_range(0, int'(ENDING_COUNT) - 1));
        case (how)
            END_PLAIN: begin
                send_text("0");
                send_byte(CH_LF);
            end
            END_WITH_CR: begin
                send_text("0");
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
            BAD_FIRST_CHAR: begin
                do b = 8'($urandom_range(0, 255));
                while (hex_val(b) >= 0 || b == CH_LF || b == CH_CR);
                send_byte(b);
                send_text("1");
                send_byte(CH_LF);
            end
            LEADING_ZERO: begin
                if ($urandom_range(0, 1) != 0) send_text("00");
                else send_text("0;x");
                send_byte(CH_LF);
            end
            SIZE_OVERFLOW: begin
                send_text("80000000");
                send_byte(CH_LF);
            end
            CR_IN_SIZE: begin
                send_text("1");
                send_byte(CH_CR);
                send_text("x");
                send_byte(CH_LF);
            end
            SIZE_LINE_LONG: begin
                send_text("1;");
                repeat (int'(max_len) - 1) send_byte(non_lf_byte());
            end
            CRLF_MISSING: begin
                send_text("1");
                send_byte(CH_LF);
                send_byte(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 2))
                    0: ;
                    1: begin
                        send_text("x");
                        send_byte(CH_CR);
                    end
                    default: begin
                        send_byte(CH_CR);
                        send_byte(CH_CR);
                    end
                endcase
                send_byte(CH_LF);
            end
            default: begin
                send_text("1");
                send_byte(CH_LF);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(CH_CR);
                repeat (int'(max_len)) send_byte(non_lf_byte());
            end
        endcase
    endtask

    // Once halted, every byte must repeat the final status.
    task automatic test_after_halt();
        repeat (40) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Sequence and end of run
    // ------------------------------------------------------------------

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("status: fail");
        $finish;
    end

    initial begin
        reset_decoder();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_shortest_lines();
        test_longest_lines();
        test_output_stall();
        test_random_limits();
        test_message_end();
        test_after_halt();
        drain_results();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/hcd_pkg.sv
sv/hcd_step.sv
sv/http_chunked_decoder_unit.sv
tb/testbench.sv
